[hdl/smb_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// smb_pkg: shared definitions for the stack bytecode machine
// Sizes, opcodes, status codes and the command/status bundles that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package smb_pkg;

  // Sizes
  localparam int STACK_DEPTH = 4096;
  localparam int CODE_DEPTH  = 65536;
  localparam int WORD_W      = 64;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int SP_W        = ADDR_W + 1;
  localparam int IDX_W       = 16;
  localparam int SUM_W       = WORD_W + 2;
  localparam int DCNT_W      = $clog2(WORD_W) + 1;

  // Opcodes
  localparam logic [4:0] OP_PUSH    = 5'd1;
  localparam logic [4:0] OP_PUT     = 5'd2;
  localparam logic [4:0] OP_RETR    = 5'd3;
  localparam logic [4:0] OP_PRINTS  = 5'd4;
  localparam logic [4:0] OP_PENTRY  = 5'd5;
  localparam logic [4:0] OP_PEXIT   = 5'd6;
  localparam logic [4:0] OP_ADD     = 5'd9;
  localparam logic [4:0] OP_MULT    = 5'd10;
  localparam logic [4:0] OP_SUBT    = 5'd11;
  localparam logic [4:0] OP_DIV     = 5'd12;
  localparam logic [4:0] OP_PRINTI  = 5'd13;
  localparam logic [4:0] OP_STRCAT  = 5'd14;
  localparam logic [4:0] OP_GT      = 5'd15;
  localparam logic [4:0] OP_LT      = 5'd16;
  localparam logic [4:0] OP_NEQ     = 5'd17;
  localparam logic [4:0] OP_EQ      = 5'd18;
  localparam logic [4:0] OP_JZ      = 5'd19;
  localparam logic [4:0] OP_J       = 5'd20;
  localparam logic [4:0] OP_NEWARR  = 5'd21;
  localparam logic [4:0] OP_PUTI    = 5'd22;
  localparam logic [4:0] OP_RETRI   = 5'd23;
  localparam logic [4:0] OP_LEN     = 5'd24;
  localparam logic [4:0] OP_DISC    = 5'd25;
  localparam logic [4:0] OP_CALL    = 5'd26;
  localparam logic [4:0] OP_FENTRY  = 5'd27;
  localparam logic [4:0] OP_FEXIT   = 5'd28;
  localparam logic [4:0] OP_RET     = 5'd30;

  // Status codes
  localparam logic [2:0] ST_RUN     = 3'd0;
  localparam logic [2:0] ST_EXIT    = 3'd1;
  localparam logic [2:0] ST_INVALID = 3'd2;
  localparam logic [2:0] ST_UNIMPL  = 3'd3;
  localparam logic [2:0] ST_BOUND   = 3'd4;
  localparam logic [2:0] ST_DIVZERO = 3'd5;
  localparam logic [2:0] ST_JUMP    = 3'd6;
  localparam logic [2:0] ST_HALTED  = 3'd7;

  // Echo kinds
  localparam logic [1:0] ECHO_NONE = 2'd0;
  localparam logic [1:0] ECHO_INT  = 2'd1;
  localparam logic [1:0] ECHO_STR  = 2'd2;

  typedef enum logic [1:0] {
    RD_FIRST,
    RD_SECOND,
    RD_THIRD,
    RD_MOVE
  } rd_sel_e;

  typedef enum logic [2:0] {
    WR_MAIN,
    WR_MOVE,
    WR_LINK0,
    WR_LINK1,
    WR_LINK2
  } wr_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic       load;
    logic       rd_en;
    rd_sel_e    rd_sel;
    logic       cap_a;
    logic       cap_b;
    logic       cap_c;
    logic       st_pre;
    logic       st_post;
    logic       mul_en;
    logic [1:0] mul_step;
    logic       div_start;
    logic       div_step;
    logic       wr_en;
    wr_sel_e    wr_sel;
    logic       mv_load;
    logic       mv_dec;
    logic       finish;
  } smb_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic       pre_run;
    logic       post_run;
    logic [1:0] n_reads;
    logic       is_mul;
    logic       is_div;
    logic       is_call;
    logic       has_wr;
    logic       mv_zero;
    logic       div_done;
    logic       out_free;
  } smb_stat_t;

endpackage
`default_nettype wire

[hdl/smb_req_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// smb_req_if: instruction channel
// Valid/ready channel carrying one bytecode instruction per beat.
// ----------------------------------------------------------------------------
interface smb_req_if;
  logic        valid;
  logic        ready;
  logic [4:0]  req_type;
  logic [63:0] param_one;
  logic [63:0] param_two;

  modport source (output valid, output req_type, output param_one, output param_two,
                  input ready);
  modport sink   (input valid, input req_type, input param_one, input param_two,
                  output ready);
endinterface
`default_nettype wire

[hdl/smb_rsp_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// smb_rsp_if: result channel
// Valid/ready channel carrying one execution result per beat.
// ----------------------------------------------------------------------------
interface smb_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] next_index;
  logic [1:0]  echo_kind;
  logic [63:0] echo_value;
  logic [2:0]  status;

  modport source (output valid, output next_index, output echo_kind, output echo_value,
                  output status, input ready);
  modport sink   (input valid, input next_index, input echo_kind, input echo_value,
                  input status, output ready);
endinterface
`default_nettype wire

[hdl/smb_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// smb_ctrl: instruction sequencer
// Steps each instruction through check, operand reads, execute, optional
// multi-cycle arithmetic or frame move, and result hand-off.
// ----------------------------------------------------------------------------
module smb_ctrl
  import smb_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire smb_stat_t stat_i,
  output smb_cmd_t       cmd_o
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CHECK = 5'd1;
  localparam logic [4:0] S_R1    = 5'd2;
  localparam logic [4:0] S_R2    = 5'd3;
  localparam logic [4:0] S_R3    = 5'd4;
  localparam logic [4:0] S_EXEC  = 5'd5;
  localparam logic [4:0] S_MUL0  = 5'd6;
  localparam logic [4:0] S_MUL1  = 5'd7;
  localparam logic [4:0] S_MUL2  = 5'd8;
  localparam logic [4:0] S_DIV   = 5'd9;
  localparam logic [4:0] S_WB    = 5'd10;
  localparam logic [4:0] S_MVRD  = 5'd11;
  localparam logic [4:0] S_MVWR  = 5'd12;
  localparam logic [4:0] S_LINK0 = 5'd13;
  localparam logic [4:0] S_LINK1 = 5'd14;
  localparam logic [4:0] S_LINK2 = 5'd15;
  localparam logic [4:0] S_DONE  = 5'd16;

  logic [4:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.st_pre = 1'b1;
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_FIRST;
        if (!stat_i.pre_run) state_d = S_DONE;
        else if (stat_i.n_reads != 2'd0) state_d = S_R1;
        else state_d = S_EXEC;
      end
      S_R1: begin
        cmd_o.cap_a  = 1'b1;
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_SECOND;
        state_d      = (stat_i.n_reads >= 2'd2) ? S_R2 : S_EXEC;
      end
      S_R2: begin
        cmd_o.cap_b  = 1'b1;
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_THIRD;
        state_d      = (stat_i.n_reads == 2'd3) ? S_R3 : S_EXEC;
      end
      S_R3: begin
        cmd_o.cap_c = 1'b1;
        state_d     = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.st_post = 1'b1;
        if (!stat_i.post_run) begin
          state_d = S_DONE;
        end else if (stat_i.is_mul) begin
          state_d = S_MUL0;
        end else if (stat_i.is_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else if (stat_i.is_call) begin
          cmd_o.mv_load = 1'b1;
          state_d       = S_MVRD;
        end else begin
          cmd_o.wr_en  = stat_i.has_wr;
          cmd_o.wr_sel = WR_MAIN;
          state_d      = S_DONE;
        end
      end
      S_MUL0: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_step = 2'd0;
        state_d        = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_step = 2'd1;
        state_d        = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_step = 2'd2;
        state_d        = S_WB;
      end
      S_DIV: begin
        if (stat_i.div_done) state_d = S_WB;
        else cmd_o.div_step = 1'b1;
      end
      S_WB: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_MAIN;
        state_d      = S_DONE;
      end
      // Shift the call arguments up by three words, top first
      S_MVRD: begin
        if (stat_i.mv_zero) begin
          state_d = S_LINK0;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_MOVE;
          cmd_o.mv_dec = 1'b1;
          state_d      = S_MVWR;
        end
      end
      S_MVWR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_MOVE;
        state_d      = S_MVRD;
      end
      S_LINK0: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_LINK0;
        state_d      = S_LINK1;
      end
      S_LINK1: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_LINK1;
        state_d      = S_LINK2;
      end
      S_LINK2: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_LINK2;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

endmodule
`default_nettype wire

[hdl/smb_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// smb_dp: machine datapath
// Stack store, pointers, bound checks, ALU with shared multiplier and
// radix-2 divider, call frame mover and the result register.
// ----------------------------------------------------------------------------
module smb_dp
  import smb_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire smb_cmd_t    cmd_i,
  output smb_stat_t        stat_o,
  input  wire logic [4:0]  req_type_i,
  input  wire logic [63:0] param_one_i,
  input  wire logic [63:0] param_two_i,
  input  wire logic        out_ready_i,
  output logic             out_valid_o,
  output logic [15:0]      next_index_o,
  output logic [1:0]       echo_kind_o,
  output logic [63:0]      echo_value_o,
  output logic [2:0]       status_o
);

  // State
  logic [SP_W-1:0]   sp_q, fp_q;
  logic [IDX_W-1:0]  ip_q;
  logic              halted_q, out_valid_q;
  logic [DCNT_W-1:0] div_cnt_q;

  // Working registers
  logic [4:0]        op_q;
  logic [WORD_W-1:0] p1_q, p2_q, a_q, b_q, c_q, rd_q;
  logic [2:0]        st_q;
  logic [WORD_W-1:0] mul_q, rem_q, quo_q, ub_q;
  logic [SP_W-1:0]   mv_q, base_q;
  logic [WORD_W-1:0] stack_mem_q [STACK_DEPTH];

  // Offset sums, wide enough never to overflow
  logic [SUM_W-1:0] p1_x, p2_x, fp_off, ip_off, sp_p2, fe_u;
  assign p1_x   = {{2{p1_q[WORD_W-1]}}, p1_q};
  assign p2_x   = {{2{p2_q[WORD_W-1]}}, p2_q};
  assign fp_off = {{(SUM_W-SP_W){1'b0}}, fp_q} + p1_x;
  assign ip_off = {{(SUM_W-IDX_W){1'b0}}, ip_q} + p1_x;
  assign sp_p2  = {{(SUM_W-SP_W){1'b0}}, sp_q} + p2_x;
  assign fe_u   = sp_p2 - p1_x;

  logic fp_slot_ok, fp_top_ok, jt_ok, fe_t_ok, fe_u_ok, next_ok;
  logic sp_room, sp_ge1, sp_ge2, call_bad, fx_bad, a_zero;
  assign fp_slot_ok = !fp_off[SUM_W-1] && (fp_off < SUM_W'(STACK_DEPTH));
  assign fp_top_ok  = !fp_off[SUM_W-1] && (fp_off <= SUM_W'(STACK_DEPTH));
  assign jt_ok      = !ip_off[SUM_W-1] && (ip_off < SUM_W'(CODE_DEPTH));
  assign fe_t_ok    = !sp_p2[SUM_W-1] && (sp_p2 <= SUM_W'(STACK_DEPTH));
  assign fe_u_ok    = !fe_u[SUM_W-1] && (fe_u <= SUM_W'(STACK_DEPTH));
  assign next_ok    = ({1'b0, ip_q} + (IDX_W+1)'(1)) < (IDX_W+1)'(CODE_DEPTH);
  assign sp_room    = sp_q < SP_W'(STACK_DEPTH);
  assign sp_ge1     = sp_q != '0;
  assign sp_ge2     = sp_q >= SP_W'(2);
  assign call_bad   = p2_q[WORD_W-1]
                    || (p2_q > {{(WORD_W-SP_W){1'b0}}, sp_q})
                    || (({1'b0, sp_q} + (SP_W+1)'(3)) > (SP_W+1)'(STACK_DEPTH));
  assign fx_bad     = (fp_q < SP_W'(2))
                    || ((op_q == OP_RET) && (!sp_ge1 || (fp_q < SP_W'(3))));
  assign a_zero     = a_q == '0;

  // Checks before any operand read
  logic [2:0] pre_st;
  always_comb begin
    pre_st = ST_RUN;
    if (halted_q) begin
      pre_st = ST_HALTED;
    end else begin
      unique case (op_q) inside
        OP_PUSH: begin
          if (!sp_room) pre_st = ST_BOUND;
          else if (!next_ok) pre_st = ST_JUMP;
        end
        OP_PUT: begin
          if (!sp_ge1 || !fp_slot_ok) pre_st = ST_BOUND;
          else if (!next_ok) pre_st = ST_JUMP;
        end
        OP_RETR: begin
          if (!sp_room || !fp_slot_ok) pre_st = ST_BOUND;
          else if (!next_ok) pre_st = ST_JUMP;
        end
        OP_PRINTS, OP_PRINTI, OP_DISC: begin
          if (!sp_ge1) pre_st = ST_BOUND;
          else if (!next_ok) pre_st = ST_JUMP;
        end
        OP_PENTRY: begin
          if (!fp_top_ok) pre_st = ST_BOUND;
          else if (!next_ok) pre_st = ST_JUMP;
        end
        OP_PEXIT: pre_st = ST_EXIT;
        OP_ADD, OP_MULT, OP_SUBT, OP_DIV, OP_GT, OP_LT, OP_NEQ, OP_EQ: begin
          if (!sp_ge2) pre_st = ST_BOUND;
        end
        OP_JZ: begin
          if (!sp_ge1) pre_st = ST_BOUND;
        end
        OP_J: begin
          if (!jt_ok) pre_st = ST_JUMP;
        end
        OP_CALL: begin
          if (call_bad) pre_st = ST_BOUND;
          else if (!jt_ok) pre_st = ST_JUMP;
        end
        OP_FENTRY: begin
          if (!fe_t_ok || !fe_u_ok) pre_st = ST_BOUND;
          else if (!next_ok) pre_st = ST_JUMP;
        end
        OP_FEXIT, OP_RET: begin
          if (fx_bad) pre_st = ST_BOUND;
        end
        OP_STRCAT, OP_NEWARR, OP_PUTI, OP_RETRI, OP_LEN: pre_st = ST_UNIMPL;
        default: pre_st = ST_INVALID;
      endcase
    end
  end

  // Checks on the operands read from the stack
  logic [2:0] post_st;
  always_comb begin
    post_st = ST_RUN;
    unique case (op_q) inside
      OP_ADD, OP_MULT, OP_SUBT, OP_DIV, OP_GT, OP_LT, OP_NEQ, OP_EQ: begin
        if ((op_q == OP_DIV) && (b_q == '0)) post_st = ST_DIVZERO;
        else if (!next_ok) post_st = ST_JUMP;
      end
      OP_JZ: begin
        if (a_zero ? !jt_ok : !next_ok) post_st = ST_JUMP;
      end
      OP_FEXIT, OP_RET: begin
        if (a_q[WORD_W-1] || (a_q > WORD_W'(STACK_DEPTH))) post_st = ST_BOUND;
        else if (b_q[WORD_W-1] || (b_q >= WORD_W'(CODE_DEPTH))) post_st = ST_JUMP;
      end
      default: post_st = ST_RUN;
    endcase
  end

  // Operand reads, main write and op class
  logic [ADDR_W-1:0] rd_first, rd_second, main_addr;
  logic [WORD_W-1:0] main_data, alu_res, div_res;
  logic [1:0]        n_reads;
  logic              is_arith, has_wr;
  logic [SP_W-1:0]   sp_m1, sp_m2;
  assign sp_m1 = sp_q - SP_W'(1);
  assign sp_m2 = sp_q - SP_W'(2);

  always_comb begin
    rd_first  = sp_m1[ADDR_W-1:0];
    rd_second = sp_m1[ADDR_W-1:0];
    main_addr = sp_q[ADDR_W-1:0];
    main_data = p1_q;
    n_reads   = 2'd0;
    is_arith  = 1'b0;
    has_wr    = 1'b0;
    unique case (op_q) inside
      OP_PUSH: has_wr = 1'b1;
      OP_PUT: begin
        n_reads   = 2'd1;
        has_wr    = 1'b1;
        main_addr = fp_off[ADDR_W-1:0];
        main_data = a_q;
      end
      OP_RETR: begin
        n_reads   = 2'd1;
        has_wr    = 1'b1;
        rd_first  = fp_off[ADDR_W-1:0];
        main_data = a_q;
      end
      OP_PRINTS, OP_PRINTI, OP_JZ: n_reads = 2'd1;
      OP_ADD, OP_MULT, OP_SUBT, OP_DIV, OP_GT, OP_LT, OP_NEQ, OP_EQ: begin
        n_reads   = 2'd2;
        is_arith  = 1'b1;
        has_wr    = 1'b1;
        rd_first  = sp_m2[ADDR_W-1:0];
        main_addr = sp_m2[ADDR_W-1:0];
        main_data = alu_res;
      end
      OP_FEXIT, OP_RET: begin
        n_reads   = (op_q == OP_RET) ? 2'd3 : 2'd2;
        has_wr    = op_q == OP_RET;
        rd_first  = fp_q[ADDR_W-1:0] - ADDR_W'(2);
        rd_second = fp_q[ADDR_W-1:0] - ADDR_W'(1);
        main_addr = fp_q[ADDR_W-1:0] - ADDR_W'(3);
        main_data = c_q;
      end
      default: n_reads = 2'd0;
    endcase
  end

  // ALU result
  assign div_res = (a_q[WORD_W-1] ^ b_q[WORD_W-1]) ? (WORD_W'(0) - quo_q) : quo_q;
  always_comb begin
    case (op_q)
      OP_ADD:  alu_res = a_q + b_q;
      OP_SUBT: alu_res = a_q - b_q;
      OP_MULT: alu_res = mul_q;
      OP_DIV:  alu_res = div_res;
      OP_GT:   alu_res = WORD_W'($signed(a_q) > $signed(b_q));
      OP_LT:   alu_res = WORD_W'($signed(a_q) < $signed(b_q));
      OP_NEQ:  alu_res = WORD_W'(a_q != b_q);
      default: alu_res = WORD_W'(a_q == b_q);
    endcase
  end

  // Shared 32x32 multiplier, one partial product a step
  localparam int HALF_W = WORD_W / 2;
  logic [HALF_W-1:0] mul_x, mul_y;
  logic [WORD_W-1:0] mul_p;
  always_comb begin
    case (cmd_i.mul_step)
      2'd0: begin mul_x = a_q[HALF_W-1:0]; mul_y = b_q[HALF_W-1:0]; end
      2'd1: begin mul_x = a_q[HALF_W-1:0]; mul_y = b_q[WORD_W-1:HALF_W]; end
      default: begin mul_x = a_q[WORD_W-1:HALF_W]; mul_y = b_q[HALF_W-1:0]; end
    endcase
  end
  assign mul_p = WORD_W'(mul_x) * WORD_W'(mul_y);

  // Restoring divider on magnitudes, one quotient bit a step
  logic [WORD_W:0] rem_sh, rem_diff;
  assign rem_sh   = {rem_q, quo_q[WORD_W-1]};
  assign rem_diff = rem_sh - {1'b0, ub_q};

  // Read and write addresses
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [WORD_W-1:0] wr_data;
  always_comb begin
    case (cmd_i.rd_sel)
      RD_FIRST:  rd_addr = rd_first;
      RD_SECOND: rd_addr = rd_second;
      RD_THIRD:  rd_addr = sp_m1[ADDR_W-1:0];
      default:   rd_addr = base_q[ADDR_W-1:0] + mv_q[ADDR_W-1:0] - ADDR_W'(1);
    endcase
  end
  always_comb begin
    case (cmd_i.wr_sel)
      WR_MAIN: begin
        wr_addr = main_addr;
        wr_data = main_data;
      end
      WR_MOVE: begin
        wr_addr = base_q[ADDR_W-1:0] + mv_q[ADDR_W-1:0] + ADDR_W'(3);
        wr_data = rd_q;
      end
      WR_LINK0: begin
        wr_addr = base_q[ADDR_W-1:0];
        wr_data = '0;
      end
      WR_LINK1: begin
        wr_addr = base_q[ADDR_W-1:0] + ADDR_W'(1);
        wr_data = {{(WORD_W-SP_W){1'b0}}, fp_q};
      end
      default: begin
        // return index may be one past the last code slot
        wr_addr = base_q[ADDR_W-1:0] + ADDR_W'(2);
        wr_data = {{(WORD_W-IDX_W-1){1'b0}}, {1'b0, ip_q} + (IDX_W+1)'(1)};
      end
    endcase
  end

  // Stack store
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) stack_mem_q[wr_addr] <= wr_data;
    if (cmd_i.rd_en) rd_q <= stack_mem_q[rd_addr];
  end

  // Pointer updates on commit
  logic [SP_W-1:0]  sp_n, fp_n;
  logic [IDX_W-1:0] ip_n;
  always_comb begin
    sp_n = sp_q;
    fp_n = fp_q;
    ip_n = ip_q + IDX_W'(1);
    unique case (op_q) inside
      OP_PUSH, OP_RETR: sp_n = sp_q + SP_W'(1);
      OP_PUT, OP_PRINTS, OP_PRINTI, OP_DISC,
      OP_ADD, OP_MULT, OP_SUBT, OP_DIV, OP_GT, OP_LT, OP_NEQ, OP_EQ: sp_n = sp_m1;
      OP_PENTRY: sp_n = fp_off[SP_W-1:0];
      OP_JZ: begin
        sp_n = sp_m1;
        if (a_zero) ip_n = ip_off[IDX_W-1:0];
      end
      OP_J: ip_n = ip_off[IDX_W-1:0];
      OP_CALL: begin
        sp_n = sp_q + SP_W'(3);
        ip_n = ip_off[IDX_W-1:0];
      end
      OP_FENTRY: begin
        sp_n = sp_p2[SP_W-1:0];
        fp_n = fe_u[SP_W-1:0];
      end
      OP_FEXIT, OP_RET: begin
        sp_n = fp_q - SP_W'(2);
        fp_n = a_q[SP_W-1:0];
        ip_n = b_q[IDX_W-1:0];
      end
      default: ip_n = ip_q + IDX_W'(1);
    endcase
  end

  logic run;
  assign run = st_q == ST_RUN;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q        <= '0;
      fp_q        <= '0;
      ip_q        <= '0;
      halted_q    <= 1'b0;
      out_valid_q <= 1'b0;
      div_cnt_q   <= '0;
    end else begin
      if (cmd_i.div_start) div_cnt_q <= DCNT_W'(WORD_W);
      else if (cmd_i.div_step) div_cnt_q <= div_cnt_q - DCNT_W'(1);
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
        if (run) begin
          sp_q <= sp_n;
          fp_q <= fp_n;
          ip_q <= ip_n;
        end else begin
          halted_q <= 1'b1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= req_type_i;
      p1_q <= param_one_i;
      p2_q <= param_two_i;
    end
    if (cmd_i.cap_a) a_q <= rd_q;
    if (cmd_i.cap_b) b_q <= rd_q;
    if (cmd_i.cap_c) c_q <= rd_q;
    if (cmd_i.st_pre) st_q <= pre_st;
    else if (cmd_i.st_post) st_q <= post_st;
    // accumulate partial products
    if (cmd_i.mul_en) begin
      if (cmd_i.mul_step == 2'd0) mul_q <= mul_p;
      else mul_q <= mul_q + {mul_p[HALF_W-1:0], {HALF_W{1'b0}}};
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= a_q[WORD_W-1] ? (WORD_W'(0) - a_q) : a_q;
      ub_q  <= b_q[WORD_W-1] ? (WORD_W'(0) - b_q) : b_q;
    end else if (cmd_i.div_step) begin
      if (!rem_diff[WORD_W]) begin
        rem_q <= rem_diff[WORD_W-1:0];
        quo_q <= {quo_q[WORD_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[WORD_W-1:0];
        quo_q <= {quo_q[WORD_W-2:0], 1'b0};
      end
    end
    // frame mover
    if (cmd_i.mv_load) begin
      mv_q   <= p2_q[SP_W-1:0];
      base_q <= sp_q - p2_q[SP_W-1:0];
    end else if (cmd_i.mv_dec) begin
      mv_q <= mv_q - SP_W'(1);
    end
    // result
    if (cmd_i.finish) begin
      next_index_o <= run ? ip_n : ip_q;
      status_o     <= st_q;
      if (run && (op_q == OP_PRINTS)) begin
        echo_kind_o  <= ECHO_STR;
        echo_value_o <= a_q;
      end else if (run && (op_q == OP_PRINTI)) begin
        echo_kind_o  <= ECHO_INT;
        echo_value_o <= a_q;
      end else begin
        echo_kind_o  <= ECHO_NONE;
        echo_value_o <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  // Status to the sequencer
  always_comb begin
    stat_o          = '0;
    stat_o.pre_run  = pre_st == ST_RUN;
    stat_o.post_run = post_st == ST_RUN;
    stat_o.n_reads  = n_reads;
    stat_o.is_mul   = is_arith && (op_q == OP_MULT);
    stat_o.is_div   = is_arith && (op_q == OP_DIV);
    stat_o.is_call  = op_q == OP_CALL;
    stat_o.has_wr   = has_wr;
    stat_o.mv_zero  = mv_q == '0;
    stat_o.div_done = div_cnt_q == '0;
    stat_o.out_free = !out_valid_q || out_ready_i;
  end

endmodule
`default_nettype wire

[hdl/stack_bytecode_machine.sv]
`default_nettype none
// Executes one bytecode instruction per beat on req_i against a 4096-word
// operand stack and returns one result beat on rsp_o. Instructions run one
// at a time through a stack store with registered reads: each steps through
// check, one read per stack operand, execute and hand-off; multiply adds
// three 32x32 partial products and a write-back, divide one quotient bit a
// cycle, and call reads and writes each argument word once to move it up
// three words, then writes the link words. A new instruction is taken
// while the previous result still waits on rsp_o. After an error or exit
// the machine answers every later instruction with status 7 until reset.
// ----------------------------------------------------------------------------
// stack_bytecode_machine: stack bytecode interpreter, top level
// Joins the sequencer and the datapath to the instruction and result
// channels.
// ----------------------------------------------------------------------------
module stack_bytecode_machine
  import smb_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  smb_req_if.sink   req_i,
  smb_rsp_if.source rsp_o
);

  smb_cmd_t  cmd;
  smb_stat_t stat;
  logic      in_ready;

  assign req_i.ready = in_ready;

  smb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  smb_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .req_type_i   (req_i.req_type),
    .param_one_i  (req_i.param_one),
    .param_two_i  (req_i.param_two),
    .out_ready_i  (rsp_o.ready),
    .out_valid_o  (rsp_o.valid),
    .next_index_o (rsp_o.next_index),
    .echo_kind_o  (rsp_o.echo_kind),
    .echo_value_o (rsp_o.echo_value),
    .status_o     (rsp_o.status)
  );

endmodule
`default_nettype wire
